[hdl/assert_macros.svh]
// Assertion macros shared by the sorted time point table RTL.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// A consequence that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/stpt_pkg.sv]
// Package for the sorted time point table: sizes, codes, word types and
// the sizing functions of the result reduction tree. Depends on nothing.
package stpt_pkg;

	// Table geometry.
	localparam int DEPTH = 64;
	localparam int KEY_W = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int FANIN = 8;

	// Number of registered levels needed to reduce DEPTH leaves.
	function automatic int tree_levels(input int leaves);
		int lv;
		int span;
		lv = 1;
		span = FANIN;
		while (span < leaves) begin
			span = span * FANIN;
			lv = lv + 1;
		end
		return lv;
	endfunction

	localparam int TREE_LVLS = tree_levels(DEPTH);

	// Number of nodes on a level, level 1 being nearest the leaves.
	function automatic int tree_width(input int lvl);
		int w;
		w = 1;
		for (int j = lvl; j < TREE_LVLS; j++) begin
			w = w * FANIN;
		end
		return w;
	endfunction

	// Index of the first node of a level in the flat node store.
	function automatic int tree_base(input int lvl);
		int b;
		b = 0;
		for (int j = 1; j < lvl; j++) begin
			b = b + tree_width(j);
		end
		return b;
	endfunction

	localparam int TREE_NODES = tree_base(TREE_LVLS) + 1;

	// Operation codes.
	localparam logic [2:0] KIND_INSERT = 3'd0;
	localparam logic [2:0] KIND_REMOVE = 3'd1;
	localparam logic [2:0] KIND_EXACT  = 3'd2;
	localparam logic [2:0] KIND_FLOOR  = 3'd3;
	localparam logic [2:0] KIND_NEXT   = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_DUP    = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	// Command word.
	typedef struct packed {
		logic [2:0]              kind;
		logic signed [KEY_W-1:0] time_req;
	} cmd_t;

	// Result word.
	typedef struct packed {
		logic                    found;
		logic signed [KEY_W-1:0] time_found;
		logic [1:0]              status;
		logic [6:0]              count;
	} rsp_t;

	// Control broadcast to every cell.
	typedef struct packed {
		logic                    cmp;
		logic                    ins;
		logic                    rem;
		logic                    sel_floor;
		logic                    sel_next;
		logic signed [KEY_W-1:0] cmp_key;
		logic signed [KEY_W-1:0] ins_key;
	} cell_ctl_t;

	// What a cell shows its neighbours.
	typedef struct packed {
		logic                    valid;
		logic                    lt;
		logic                    gt;
		logic signed [KEY_W-1:0] key;
	} nbr_t;

	// One leaf or node of the result reduction tree.
	typedef struct packed {
		logic             eq;
		logic             pick;
		logic [KEY_W-1:0] key;
	} leaf_t;

endpackage

[hdl/stpt_cell.sv]
// One cell of the sorted key chain: a key, its valid bit and the comparison
// flags of the current operation. Depends on stpt_pkg.
module stpt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  stpt_pkg::cell_ctl_t ctl,
	input  stpt_pkg::nbr_t    prev,
	input  stpt_pkg::nbr_t    next,
	output stpt_pkg::nbr_t    own,
	output stpt_pkg::leaf_t   leaf
);

	logic signed [stpt_pkg::KEY_W-1:0] key_q;
	logic valid_q;
	logic lt_q;
	logic eq_q;
	logic gt;
	logic fl_pick;
	logic nx_pick;
	logic pick;

	// Compare on acceptance; shift valid bits on insert or remove.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else if (ctl.cmp) begin
			lt_q <= valid_q && (key_q < ctl.cmp_key);
			eq_q <= valid_q && (key_q == ctl.cmp_key);
		end else if (ctl.ins && !lt_q) begin
			valid_q <= prev.valid;
		end else if (ctl.rem && !lt_q) begin
			valid_q <= next.valid;
		end
	end

	// Keys at or above the position move right on insert, left on remove.
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt_q) begin
			key_q <= prev.lt ? ctl.ins_key : prev.key;
		end else if (ctl.rem && !lt_q) begin
			key_q <= next.key;
		end
	end

	// The last key below the request is the floor; the first above is the next.
	assign gt      = valid_q && !lt_q && !eq_q;
	assign fl_pick = lt_q && !next.lt;
	assign nx_pick = gt && !prev.gt;
	assign pick    = (ctl.sel_floor && fl_pick) || (ctl.sel_next && nx_pick);

	assign own.valid = valid_q;
	assign own.lt    = lt_q;
	assign own.gt    = gt;
	assign own.key   = key_q;

	assign leaf.eq   = eq_q;
	assign leaf.pick = pick;
	assign leaf.key  = pick ? key_q : '0;

endmodule

[hdl/stpt_or_tree.sv]
// Registered OR tree that gathers the hit flag and the one picked key from
// all cells, one level per clock. Depends on stpt_pkg.
module stpt_or_tree (
	input  logic            clk,
	input  stpt_pkg::leaf_t leaves [stpt_pkg::DEPTH],
	output stpt_pkg::leaf_t root
);

	stpt_pkg::leaf_t node_q [stpt_pkg::TREE_NODES];

	// At most one child carries a key, so an OR merges them.
	function automatic stpt_pkg::leaf_t leaf_reduce(input stpt_pkg::leaf_t kid [stpt_pkg::FANIN]);
		stpt_pkg::leaf_t acc;
		acc = '0;
		for (int c = 0; c < stpt_pkg::FANIN; c++) begin
			acc = acc | kid[c];
		end
		return acc;
	endfunction

	genvar lv, n, c;
	generate
		for (lv = 1; lv <= stpt_pkg::TREE_LVLS; lv++) begin : g_lvl
			for (n = 0; n < stpt_pkg::tree_width(lv); n++) begin : g_node
				stpt_pkg::leaf_t kid [stpt_pkg::FANIN];

				// Children are cell leaves on the first level, nodes above it.
				for (c = 0; c < stpt_pkg::FANIN; c++) begin : g_kid
					if (lv == 1) begin : g_leaf
						if (n * stpt_pkg::FANIN + c < stpt_pkg::DEPTH) begin : g_real
							assign kid[c] = leaves[n * stpt_pkg::FANIN + c];
						end else begin : g_pad
							assign kid[c] = '0;
						end
					end else begin : g_inner
						assign kid[c] = node_q[stpt_pkg::tree_base(lv - 1)
							+ n * stpt_pkg::FANIN + c];
					end
				end

				always_ff @(posedge clk) begin
					node_q[stpt_pkg::tree_base(lv) + n] <= leaf_reduce(kid);
				end
			end
		end
	endgenerate

	assign root = node_q[stpt_pkg::TREE_NODES - 1];

endmodule

[hdl/sorted_time_point_table_unit.sv]
// Top level of the sorted time point table: a chain of key cells, the
// result OR tree and the operation sequencer. Depends on stpt_pkg,
// stpt_cell, stpt_or_tree and assert_macros.svh.
//
// Usage: present a command word on cmd and raise start; the word is taken
// at a rising edge where start is high and busy is low. Busy then stays
// high for the rest of the operation. The result word appears on result
// for exactly one cycle with done high; the receiver cannot stall it.
// Each command runs through these steps in order from acceptance to the next
// possible acceptance: every cell compares its key with the request, each
// level of the eight-way result tree is registered in turn, and a last
// step shifts the chain on insert or remove and registers the result.
// Done rises in the cycle after the last of these, which is also the first
// cycle in which a new command is taken.
// Keys stay sorted in ascending order in the cells below the count.
// Reset clears the valid bits, the count and the sequencer; the table is
// empty and ready in the first cycle after reset is released.
`include "assert_macros.svh"

module sorted_time_point_table_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  stpt_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done,
	output stpt_pkg::rsp_t result
);

	localparam int PH_W = $clog2(stpt_pkg::TREE_LVLS + 2);
	localparam logic [PH_W-1:0] PH_IDLE  = '0;
	localparam logic [PH_W-1:0] PH_FIRST = PH_W'(1);
	localparam logic [PH_W-1:0] PH_APPLY = PH_W'(stpt_pkg::TREE_LVLS + 1);

	logic [PH_W-1:0]          ph_q;
	logic [stpt_pkg::CNT_W-1:0] cnt_q;
	logic [stpt_pkg::CNT_W-1:0] cnt_d;
	stpt_pkg::cmd_t           req_q;
	stpt_pkg::rsp_t           rsp_d;
	stpt_pkg::rsp_t           result_q;
	logic                     done_q;
	logic                     accept;
	logic                     apply;
	logic                     ins_en;
	logic                     rem_en;
	stpt_pkg::cell_ctl_t      ctl;
	stpt_pkg::nbr_t           own_w  [stpt_pkg::DEPTH];
	stpt_pkg::leaf_t          leaf_w [stpt_pkg::DEPTH];
	stpt_pkg::leaf_t          root;
	logic [stpt_pkg::DEPTH-1:0] valid_w;

	assign busy   = (ph_q != PH_IDLE);
	assign accept = start && !busy;
	assign apply  = (ph_q == PH_APPLY);

	// Phase counter: compare, tree levels, then apply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
		end else if (accept) begin
			ph_q <= PH_FIRST;
		end else if (apply) begin
			ph_q <= PH_IDLE;
		end else if (busy) begin
			ph_q <= ph_q + PH_W'(1);
		end
	end

	// Hold the command word for the whole operation.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= cmd;
		end
	end

	// Broadcast control to the cells.
	assign ctl.cmp       = accept;
	assign ctl.ins       = ins_en;
	assign ctl.rem       = rem_en;
	assign ctl.sel_floor = (req_q.kind == stpt_pkg::KIND_FLOOR);
	assign ctl.sel_next  = (req_q.kind == stpt_pkg::KIND_NEXT);
	assign ctl.cmp_key   = cmd.time_req;
	assign ctl.ins_key   = req_q.time_req;

	// The cell chain, with fixed neighbours at both ends.
	genvar i;
	generate
		for (i = 0; i < stpt_pkg::DEPTH; i++) begin : g_cell
			stpt_pkg::nbr_t prv;
			stpt_pkg::nbr_t nxt;

			if (i == 0) begin : g_head
				assign prv = '{valid: 1'b1, lt: 1'b1, gt: 1'b0, key: '0};
			end else begin : g_mid_prev
				assign prv = own_w[i-1];
			end

			if (i == stpt_pkg::DEPTH - 1) begin : g_tail
				assign nxt = '{valid: 1'b0, lt: 1'b0, gt: 1'b0, key: '0};
			end else begin : g_mid_next
				assign nxt = own_w[i+1];
			end

			stpt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.prev   (prv),
				.next   (nxt),
				.own    (own_w[i]),
				.leaf   (leaf_w[i])
			);

			assign valid_w[i] = own_w[i].valid;
		end
	endgenerate

	stpt_or_tree u_tree (
		.clk    (clk),
		.leaves (leaf_w),
		.root   (root)
	);

	// Decide the outcome once the tree has delivered hit and picked key.
	always_comb begin
		rsp_d.found      = 1'b0;
		rsp_d.time_found = '0;
		rsp_d.status     = stpt_pkg::ST_OK;
		ins_en           = 1'b0;
		rem_en           = 1'b0;
		cnt_d            = cnt_q;
		case (req_q.kind)
			stpt_pkg::KIND_INSERT: begin
				if (root.eq) begin
					rsp_d.found      = 1'b1;
					rsp_d.time_found = req_q.time_req;
					rsp_d.status     = stpt_pkg::ST_DUP;
				end else if (cnt_q == stpt_pkg::CNT_W'(stpt_pkg::DEPTH)) begin
					rsp_d.status = stpt_pkg::ST_FULL;
				end else begin
					ins_en = apply;
					cnt_d  = cnt_q + stpt_pkg::CNT_W'(1);
				end
			end
			stpt_pkg::KIND_REMOVE: begin
				if (root.eq) begin
					rsp_d.found      = 1'b1;
					rsp_d.time_found = req_q.time_req;
					rem_en           = apply;
					cnt_d            = cnt_q - stpt_pkg::CNT_W'(1);
				end else begin
					rsp_d.status = stpt_pkg::ST_ABSENT;
				end
			end
			stpt_pkg::KIND_EXACT: begin
				if (root.eq) begin
					rsp_d.found      = 1'b1;
					rsp_d.time_found = req_q.time_req;
				end
			end
			stpt_pkg::KIND_FLOOR: begin
				if (root.eq) begin
					rsp_d.found      = 1'b1;
					rsp_d.time_found = req_q.time_req;
				end else if (root.pick) begin
					rsp_d.found      = 1'b1;
					rsp_d.time_found = root.key;
				end
			end
			stpt_pkg::KIND_NEXT: begin
				if (root.pick) begin
					rsp_d.found      = 1'b1;
					rsp_d.time_found = root.key;
				end
			end
			default: begin
			end
		endcase
		rsp_d.count = 7'(cnt_d);
	end

	// Count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= apply;
			if (apply) begin
				cnt_q <= cnt_d;
			end
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (apply) begin
			result_q <= rsp_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Checks on the sequencer and the cell chain.
	`ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`ASSERT_ALWAYS(a_done_idle, !done || !busy)
	`ASSERT_ALWAYS(a_count_range, cnt_q <= stpt_pkg::CNT_W'(stpt_pkg::DEPTH))
	`ASSERT_ALWAYS(a_valid_count, $countones(valid_w) == int'(cnt_q))

endmodule

[test/tb_sorted_time_point_table_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the sorted time point table unit.
// Depends on stpt_pkg and sorted_time_point_table_unit; runs directed then random commands.

// Scoreboard: keeps its own sorted copy of the keys and the answers still owed.
class key_table_book;
	logic signed [63:0] table_keys[$];
	stpt_pkg::rsp_t     pending_answers[$];
	int                 mismatches;

	function new();
		mismatches = 0;
	endfunction

	// Applies one accepted command word to the key copy and queues its answer.
	function void apply_command(stpt_pkg::cmd_t c);
		logic signed [63:0] k;
		int                 pos;
		int                 nxt;
		bit                 hit;
		stpt_pkg::rsp_t     r;
		k = c.time_req;
		pos = 0;
		while (pos < table_keys.size() && table_keys[pos] < k)
			pos++;
		hit = (pos < table_keys.size()) && (table_keys[pos] == k);
		r = '0;
		r.status = stpt_pkg::ST_OK;
		case (c.kind)
			stpt_pkg::KIND_INSERT: begin
				// The duplicate check takes precedence over the full check.
				if (hit) begin
					r.found = 1'b1;
					r.time_found = k;
					r.status = stpt_pkg::ST_DUP;
				end else if (table_keys.size() >= stpt_pkg::DEPTH) begin
					r.status = stpt_pkg::ST_FULL;
				end else begin
					table_keys.insert(pos, k);
				end
			end
			stpt_pkg::KIND_REMOVE: begin
				if (hit) begin
					r.found = 1'b1;
					r.time_found = k;
					table_keys.delete(pos);
				end else begin
					r.status = stpt_pkg::ST_ABSENT;
				end
			end
			stpt_pkg::KIND_EXACT: begin
				if (hit) begin
					r.found = 1'b1;
					r.time_found = k;
				end
			end
			stpt_pkg::KIND_FLOOR: begin
				// Latest key at or before the requested time.
				if (hit) begin
					r.found = 1'b1;
					r.time_found = k;
				end else if (pos > 0) begin
					r.found = 1'b1;
					r.time_found = table_keys[pos - 1];
				end
			end
			stpt_pkg::KIND_NEXT: begin
				// Smallest key strictly after the requested time.
				nxt = hit ? pos + 1 : pos;
				if (nxt < table_keys.size()) begin
					r.found = 1'b1;
					r.time_found = table_keys[nxt];
				end
			end
			default: ;
		endcase
		r.count = 7'(table_keys.size());
		pending_answers.push_back(r);
	endfunction

	task report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Compares one result word with the oldest answer owed.
	task check_answer(stpt_pkg::rsp_t got);
		stpt_pkg::rsp_t want;
		if (pending_answers.size() == 0) begin
			report_mismatch("result word with no command outstanding");
		end else begin
			want = pending_answers.pop_front();
			if (got.found !== want.found)
				report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
			if (got.time_found !== want.time_found)
				report_mismatch($sformatf("time_found %h, expected %h",
					got.time_found, want.time_found));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.count !== want.count)
				report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
		end
	endtask
endclass

module tb_sorted_time_point_table_unit;

	localparam logic signed [63:0] KEY_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] KEY_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam int IDLE_LIMIT = 1000;
	localparam int PHASES = 6;

	logic           clk;
	logic           arst_n;
	logic           start;
	stpt_pkg::cmd_t cmd;
	logic           busy;
	logic           done;
	stpt_pkg::rsp_t result;

	key_table_book book = new();
	bit idle_on = 1'b1;
	int idle_cycles = 0;

	sorted_time_point_table_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Every result word is taken at the edge that ends its strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			book.check_answer(result);
	end

	// Watchdog: ends the run when neither side moves a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_sorted_time_point_table_unit failed");
				$finish;
			end
		end
	end

	// Presents one command word, after a random gap while idle_on is set, and waits for it to be taken.
	// Start stays high between back-to-back words so it is never lowered and
	// raised in the same step.
	task send_command(logic [2:0] kind, logic signed [63:0] key);
		int             gap;
		stpt_pkg::cmd_t c;
		c.kind = kind;
		c.time_req = key;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy !== 1'b0);
		book.apply_command(c);
	endtask

	// Chooses a key: a stored one with a chance of hit_pct percent, otherwise a
	// neighbour of one, a small value, a wide random value or an extreme.
	function automatic logic signed [63:0] pick_key(int hit_pct);
		int                 n;
		int                 sel;
		int                 near;
		logic signed [63:0] k;
		n = book.table_keys.size();
		if (n > 0 && $urandom_range(0, 99) < hit_pct)
			return book.table_keys[$urandom_range(0, n - 1)];
		sel = $urandom_range(0, 9);
		if (sel < 3 && n > 0) begin
			k = book.table_keys[$urandom_range(0, n - 1)];
			k = $urandom_range(0, 1) ? k + 64'sd1 : k - 64'sd1;
		end else if (sel < 7) begin
			near = $urandom_range(0, 400);
			k = 64'(near - 200);
		end else if (sel < 9) begin
			k = {$urandom, $urandom};
		end else begin
			case ($urandom_range(0, 3))
				0: k = KEY_MIN;
				1: k = KEY_MAX;
				2: k = 64'sd0;
				default: k = -64'sd1;
			endcase
		end
		return k;
	endfunction

	initial begin
		int         phase_len[PHASES];
		int         ins_pct[PHASES];
		int         rem_pct[PHASES];
		int         counted;
		int         r;
		logic [2:0] kind;

		phase_len = '{100, 70, 70, 100, 60, 50};
		ins_pct = '{95, 40, 10, 90, 45, 5};
		rem_pct = '{2, 30, 70, 3, 35, 80};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: searches and a removal on the empty table.
		send_command(stpt_pkg::KIND_FLOOR, KEY_MAX);
		send_command(stpt_pkg::KIND_NEXT, KEY_MIN);
		send_command(stpt_pkg::KIND_REMOVE, 64'sd0);
		send_command(stpt_pkg::KIND_EXACT, 64'sd0);
		// Extreme keys, then a duplicate insert.
		send_command(stpt_pkg::KIND_INSERT, 64'sd0);
		send_command(stpt_pkg::KIND_INSERT, KEY_MIN);
		send_command(stpt_pkg::KIND_INSERT, KEY_MAX);
		send_command(stpt_pkg::KIND_INSERT, -64'sd1);
		send_command(stpt_pkg::KIND_INSERT, 64'sd0);
		// Exact hit and miss; floor on a key and between keys.
		send_command(stpt_pkg::KIND_EXACT, -64'sd1);
		send_command(stpt_pkg::KIND_EXACT, 64'sd5);
		send_command(stpt_pkg::KIND_FLOOR, 64'sd5);
		send_command(stpt_pkg::KIND_FLOOR, KEY_MIN);
		send_command(stpt_pkg::KIND_FLOOR, -64'sd2);
		// Next after the largest key, after a stored key and after an absent one.
		send_command(stpt_pkg::KIND_NEXT, KEY_MAX);
		send_command(stpt_pkg::KIND_NEXT, -64'sd1);
		send_command(stpt_pkg::KIND_NEXT, 64'sd7);
		// Removal of a present key and then of the same key again.
		send_command(stpt_pkg::KIND_REMOVE, KEY_MAX);
		send_command(stpt_pkg::KIND_REMOVE, KEY_MAX);
		send_command(stpt_pkg::KIND_FLOOR, KEY_MAX);
		// Unused operation codes leave the table alone.
		send_command(3'd5, {$urandom, $urandom});
		send_command(3'd6, {$urandom, $urandom});
		send_command(3'd7, {$urandom, $urandom});

		// Random phases go from filling the table through mixed traffic to draining it, twice.
		for (int p = 0; p < PHASES; p++) begin
			counted = 0;
			while (counted < phase_len[p]) begin
				if (counted % 25 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				r = $urandom_range(0, 99);
				if (r < ins_pct[p]) begin
					send_command(stpt_pkg::KIND_INSERT, pick_key(10));
					counted++;
				end else if (r < ins_pct[p] + rem_pct[p]) begin
					send_command(stpt_pkg::KIND_REMOVE, pick_key(80));
					counted++;
				end else if (r < 97) begin
					case ($urandom_range(0, 2))
						0: kind = stpt_pkg::KIND_EXACT;
						1: kind = stpt_pkg::KIND_FLOOR;
						default: kind = stpt_pkg::KIND_NEXT;
					endcase
					send_command(kind, pick_key(40));
					counted++;
				end else begin
					send_command(3'($urandom_range(5, 7)), {$urandom, $urandom});
				end
			end
		end
		start <= 1'b0;

		// Drain the outstanding answers, then allow time for any stray word.
		while (book.pending_answers.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (book.mismatches == 0)
			$display("tb_sorted_time_point_table_unit passed");
		else
			$display("tb_sorted_time_point_table_unit failed");
		$finish;
	end

endmodule
